// ===== rtl/core/kprm_pkg.sv =====
`default_nettype none

package kprm_pkg;

    // Sizes fixed by the field and register formats.
    localparam int MAX_PATTERN_DEF = 16;
    localparam int VEC_BITS        = 16;
    localparam int DIGIT_W         = 4;
    localparam int DIGITS_W        = 64;
    localparam int LEN_W           = 5;
    localparam int CH_W            = 8;
    localparam int CMD_W           = 2;
    localparam int CFG_IDX_W       = 1;

    // Item kinds carried on the input tuser.
    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_NAME   = 2'd0;
    localparam cmd_t CMD_NUMBER = 2'd1;
    localparam cmd_t CMD_END    = 2'd2;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_PATTERN_LEN    = 1'b0;
    localparam cfg_idx_t REG_PATTERN_DIGITS = 1'b1;

    typedef logic [CH_W-1:0]    char_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    // Character codes used by the matching rules.
    localparam char_t CH_PLUS    = 8'h2B;
    localparam char_t CH_ZERO    = 8'h30;
    localparam char_t CH_UPPER_A = 8'h41;
    localparam char_t CH_UPPER_Z = 8'h5A;
    localparam char_t CH_LOWER_A = 8'h61;
    localparam char_t CH_LOWER_C = 8'h63;
    localparam char_t CH_LOWER_D = 8'h64;
    localparam char_t CH_LOWER_F = 8'h66;
    localparam char_t CH_LOWER_G = 8'h67;
    localparam char_t CH_LOWER_I = 8'h69;
    localparam char_t CH_LOWER_J = 8'h6A;
    localparam char_t CH_LOWER_L = 8'h6C;
    localparam char_t CH_LOWER_M = 8'h6D;
    localparam char_t CH_LOWER_O = 8'h6F;
    localparam char_t CH_LOWER_P = 8'h70;
    localparam char_t CH_LOWER_S = 8'h73;
    localparam char_t CH_LOWER_T = 8'h74;
    localparam char_t CH_LOWER_V = 8'h76;
    localparam char_t CH_LOWER_W = 8'h77;
    localparam char_t CH_LOWER_Z = 8'h7A;
    localparam char_t CASE_GAP   = 8'd32;

    localparam digit_t DIGIT_ZERO = 4'd0;
    localparam digit_t DIGIT_ONE  = 4'd1;
    localparam digit_t DIGIT_MAX  = 4'd9;
    localparam digit_t KEY_NONE   = 4'd0;

    // One staged input item.
    typedef struct packed {
        cmd_t  cmd;
        char_t ch;
    } item_t;

    // Keypad key that carries a lowercase letter, or no key for anything else.
    function automatic digit_t key_of_letter(input char_t c);
        digit_t key;
        case (c) inside
            [CH_LOWER_A:CH_LOWER_C]: key = 4'd2;
            [CH_LOWER_D:CH_LOWER_F]: key = 4'd3;
            [CH_LOWER_G:CH_LOWER_I]: key = 4'd4;
            [CH_LOWER_J:CH_LOWER_L]: key = 4'd5;
            [CH_LOWER_M:CH_LOWER_O]: key = 4'd6;
            [CH_LOWER_P:CH_LOWER_S]: key = 4'd7;
            [CH_LOWER_T:CH_LOWER_V]: key = 4'd8;
            [CH_LOWER_W:CH_LOWER_Z]: key = 4'd9;
            default:                 key = KEY_NONE;
        endcase
        return key;
    endfunction

    // Does one pattern digit accept this character in the name or the number?
    function automatic logic digit_matches(input digit_t d, input char_t c,
                                           input logic in_number);
        char_t lower;
        logic  ok;
        lower = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? c + CASE_GAP : c;
        if (d > DIGIT_MAX) begin
            ok = 1'b0;
        end else if (in_number) begin
            ok = (c == CH_ZERO + {4'b0000, d});
        end else if (d == DIGIT_ZERO) begin
            ok = (lower == CH_PLUS);
        end else if (d == DIGIT_ONE) begin
            ok = 1'b0;
        end else begin
            ok = (key_of_letter(lower) == d);
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kprm_digit_match.sv =====
`default_nettype none

module kprm_digit_match #(
    parameter int VEC_W = 16
) (
    input  wire logic [kprm_pkg::LEN_W-1:0]    pattern_len,
    input  wire logic [kprm_pkg::DIGITS_W-1:0] pattern_digits,
    input  wire kprm_pkg::item_t               item,
    output logic [VEC_W-1:0]                   ok_mask,
    output logic [VEC_W-1:0]                   last_mask,
    output logic                               len_zero
);
    import kprm_pkg::*;

    localparam logic [LEN_W-1:0] VEC_W_L = LEN_W'(VEC_W);

    logic [LEN_W-1:0] eff_len;
    logic             in_number;

    // The usable length saturates at the vector width.
    assign eff_len   = (pattern_len > VEC_W_L) ? VEC_W_L : pattern_len;
    assign len_zero  = (eff_len == '0);
    assign in_number = (item.cmd == CMD_NUMBER);

    // One lane per pattern position: does this character fit that digit?
    for (genvar i = 0; i < VEC_W; i++) begin : g_lane
        assign ok_mask[i] = (LEN_W'(i) < eff_len) &&
            digit_matches(pattern_digits[i*DIGIT_W +: DIGIT_W], item.ch, in_number);
        assign last_mask[i] = (LEN_W'(i + 1) == eff_len);
    end

endmodule

`default_nettype wire

// ===== rtl/core/kprm_core.sv =====
`default_nettype none

module kprm_core #(
    parameter int VEC_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_valid,
    input  wire kprm_pkg::cmd_t    item_cmd,
    input  wire logic [VEC_W-1:0]  ok_mask,
    input  wire logic [VEC_W-1:0]  last_mask,
    input  wire logic              len_zero,
    output logic                   item_take,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic                   matched,
    output logic                   by_number
);
    import kprm_pkg::*;

    logic [VEC_W-1:0] name_vec_reg, name_vec_next;
    logic [VEC_W-1:0] num_vec_reg, num_vec_next;
    logic             name_hit_reg, name_hit_next;
    logic             num_hit_reg, num_hit_next;
    logic             m_valid_reg, m_valid_next;
    logic             matched_reg, matched_next;
    logic             by_number_reg, by_number_next;
    logic [VEC_W-1:0] name_step;
    logic [VEC_W-1:0] num_step;
    logic             is_end;

    // An end-of-record item waits while an earlier result is still unread.
    assign is_end    = (item_cmd == CMD_END);
    assign item_take = item_valid && (!is_end || !m_valid_reg || m_tready);

    // Shift-and step for each part of the record.
    assign name_step = ((name_vec_reg << 1) | VEC_W'(1)) & ok_mask;
    assign num_step  = ((num_vec_reg << 1) | VEC_W'(1)) & ok_mask;

    // Next state of the vectors, hit bits and result register.
    always_comb begin
        name_vec_next  = name_vec_reg;
        num_vec_next   = num_vec_reg;
        name_hit_next  = name_hit_reg;
        num_hit_next   = num_hit_reg;
        matched_next   = matched_reg;
        by_number_next = by_number_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        if (item_take) begin
            case (item_cmd)
                CMD_NAME: begin
                    name_vec_next = name_step;
                    if (!len_zero && |(name_step & last_mask)) begin
                        name_hit_next = 1'b1;
                    end
                end
                CMD_NUMBER: begin
                    num_vec_next = num_step;
                    if (!len_zero && |(num_step & last_mask)) begin
                        num_hit_next = 1'b1;
                    end
                end
                CMD_END: begin
                    by_number_next = len_zero || num_hit_reg;
                    matched_next   = len_zero || num_hit_reg || name_hit_reg;
                    m_valid_next   = 1'b1;
                    name_vec_next  = '0;
                    num_vec_next   = '0;
                    name_hit_next  = 1'b0;
                    num_hit_next   = 1'b0;
                end
                default: begin
                    // The unused kind is dropped without effect.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_vec_reg <= '0;
            num_vec_reg  <= '0;
            name_hit_reg <= 1'b0;
            num_hit_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            name_vec_reg <= name_vec_next;
            num_vec_reg  <= num_vec_next;
            name_hit_reg <= name_hit_next;
            num_hit_reg  <= num_hit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        matched_reg   <= matched_next;
        by_number_reg <= by_number_next;
    end

    assign m_tvalid  = m_valid_reg;
    assign matched   = matched_reg;
    assign by_number = by_number_reg;

endmodule

`default_nettype wire

// ===== rtl/core/keypad_pattern_record_matcher.sv =====
// Keypad pattern record matcher.
// Input transfers carry one record character each: s_tdata holds the byte and
// s_tuser says whether it belongs to the name, the number, or closes the record.
// The pattern registers are written through cfg_we/cfg_index/cfg_data by the
// user, only while the block is idle; the block does not enforce it. The pattern
// is searched as a contiguous substring in both parts with one shift-and vector
// per part, one bit per pattern position. Only an end-of-record transfer makes a
// result transfer: m_tdata bit 0 is the match flag and m_tuser bit 0 the number match.
// Throughput is one item per cycle while no end-of-record item waits on an unread
// result: an input register feeds the per-position digit compares and the vector
// update, into the result register. An end-of-record item passes from the input
// register to the result register that drives m_tvalid. While a result waits for
// m_tready, name and number characters keep flowing; only the next end-of-record
// item holds in the input register, and s_tready drops once that register is
// full and cannot drain.
// A synchronous active-low reset empties both registers, clears the vectors and
// hit bits, and sets the pattern length and digits to zero.
`default_nettype none

module keypad_pattern_record_matcher #(
    parameter int MAX_PATTERN = kprm_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port.
    input  wire logic                              cfg_we,
    input  wire logic [kprm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kprm_pkg::DIGITS_W-1:0]     cfg_data,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,  // [7:0] ch
    input  wire logic [1:0]                        s_tuser,  // [1:0] cmd
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,  // [0] matched, [7:1] zero
    output logic [0:0]                             m_tuser   // [0] by_number
);
    import kprm_pkg::*;

    localparam int VEC_W = (MAX_PATTERN < VEC_BITS) ? MAX_PATTERN : VEC_BITS;

    logic [LEN_W-1:0]    pattern_len_reg;
    logic [DIGITS_W-1:0] pattern_digits_reg;
    logic                in_valid_reg, in_valid_next;
    item_t               item_reg;
    logic                s_accept;
    logic                item_take;
    logic [VEC_W-1:0]    ok_mask;
    logic [VEC_W-1:0]    last_mask;
    logic                len_zero;
    logic                matched;
    logic                by_number;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_len_reg    <= '0;
            pattern_digits_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PATTERN_LEN:    pattern_len_reg    <= cfg_data[LEN_W-1:0];
                REG_PATTERN_DIGITS: pattern_digits_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register: refills in the same cycle it drains.
    assign s_tready = !in_valid_reg || item_take;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (item_take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.cmd <= s_tuser;
            item_reg.ch  <= s_tdata;
        end
    end

    kprm_digit_match #(
        .VEC_W(VEC_W)
    ) u_match (
        .pattern_len    (pattern_len_reg),
        .pattern_digits (pattern_digits_reg),
        .item           (item_reg),
        .ok_mask        (ok_mask),
        .last_mask      (last_mask),
        .len_zero       (len_zero)
    );

    kprm_core #(
        .VEC_W(VEC_W)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item_cmd   (item_reg.cmd),
        .ok_mask    (ok_mask),
        .last_mask  (last_mask),
        .len_zero   (len_zero),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .matched    (matched),
        .by_number  (by_number)
    );

    assign m_tdata = {7'b0000000, matched};
    assign m_tuser = by_number;

endmodule

`default_nettype wire

// ===== rtl/core/kprm_checker.sv =====
`default_nettype none

module kprm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [0:0] m_tuser
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A number match always counts as a match.
    a_by_number_implies_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[0])
        else $error("by_number set without matched");

    // Padding bits of the result stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:1] == 7'b0000000))
        else $error("result padding not zero");

    // A stalled result transfer is held.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind keypad_pattern_record_matcher kprm_checker u_kprm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
